// ===== src/rdd_pkg.sv =====
// rdd_pkg: shared types and constants of the RED drop decision block.
// No dependencies; used by the interfaces, the divider and the top level.
package rdd_pkg;

  localparam int QNUM_W   = 4;
  localparam int AVG_W    = 20;
  localparam int CUR_W    = 12;
  localparam int RND_W    = 16;
  localparam int ACT_W    = 2;
  localparam int THR_W    = 12;
  localparam int PROB_W   = 17;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W  = 16;
  localparam int DIV_W    = 20;
  localparam int QUO_W    = 17;
  localparam int STEP_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_THRESH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_THRESH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROB     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKING_MODE = 2'd3;

  localparam logic [ACT_W-1:0] ACT_ACCEPT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DROP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MARK   = 2'd2;

  localparam logic [PROB_W-1:0]  ONE_Q16    = 17'd65536;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'h7FFF;
  localparam logic [COUNT_W-1:0] COUNT_IDLE = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_ZERO = 16'h0000;

  localparam logic [STEP_W-1:0] DIV1_STEPS = 5'd17;
  localparam logic [STEP_W-1:0] DIV2_STEPS = 5'd16;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem_init;
    logic [QUO_W-1:0]  low_init;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_stat_t;

endpackage

// ===== src/rdd_if.sv =====
// rdd_if: valid/ready channel interfaces for arrivals and decisions.
// Depends on rdd_pkg for field widths.
interface rdd_arrival_if;
  logic                        valid;
  logic                        ready;
  logic [rdd_pkg::QNUM_W-1:0]  queue_num;
  logic [rdd_pkg::AVG_W-1:0]   avg_length;
  logic [rdd_pkg::CUR_W-1:0]   cur_length;
  logic [rdd_pkg::RND_W-1:0]   random_value;

  modport source (output valid, queue_num, avg_length, cur_length, random_value,
                  input ready);
  modport sink (input valid, queue_num, avg_length, cur_length, random_value,
                output ready);
endinterface

interface rdd_decision_if;
  logic                       valid;
  logic                       ready;
  logic [rdd_pkg::QNUM_W-1:0] queue_echo;
  logic [rdd_pkg::ACT_W-1:0]  action;

  modport source (output valid, queue_echo, action, input ready);
  modport sink (input valid, queue_echo, action, output ready);
endinterface

// ===== src/rdd_ram.sv =====
// rdd_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module rdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/rdd_divider.sv =====
// rdd_divider: shared restoring divider, one quotient bit per cycle.
// Depends on rdd_pkg for the request and status structs.
module rdd_divider (
  input  logic               clk,
  input  logic               rst,
  input  rdd_pkg::div_req_t  req,
  output rdd_pkg::div_stat_t stat
);

  logic [rdd_pkg::DIV_W-1:0]  rem;
  logic [rdd_pkg::QUO_W-1:0]  low;
  logic [rdd_pkg::QUO_W-1:0]  quo;
  logic [rdd_pkg::STEP_W-1:0] cnt;
  logic [rdd_pkg::DIV_W-1:0]  divisor;
  logic                       busy;
  logic                       done;
  logic [rdd_pkg::DIV_W:0]    trial;
  logic [rdd_pkg::DIV_W:0]    diff;
  logic                       fits;

  assign trial = {rem, low[rdd_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        rem     <= req.rem_init;
        low     <= req.low_init;
        cnt     <= req.steps;
        divisor <= req.divisor;
        quo     <= '0;
      end else if (busy) begin
        rem <= fits ? diff[rdd_pkg::DIV_W-1:0] : trial[rdd_pkg::DIV_W-1:0];
        quo <= {quo[rdd_pkg::QUO_W-2:0], fits};
        low <= {low[rdd_pkg::QUO_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == rdd_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule

// ===== src/red_drop_decision.sv =====
// red_drop_decision: RED drop/mark decision per packet arrival, per-queue counts.
// Depends on rdd_pkg, rdd_if, rdd_ram and rdd_divider.
// Outside the band the result follows the lookup; in the band it takes one divider pass
// (17 steps) when pa is one, else two (17 and 16 steps), and two uses of one multiplier.
// Throughput: one item at a time; ready only while idle; the result register frees input.
// Reset: synchronous; thresholds and probability take their defaults, counts read as -1.
module red_drop_decision #(
  parameter int NUM_QUEUES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  rdd_arrival_if.sink                     arrival,
  rdd_decision_if.source                  decision,
  input  logic                            cfg_wr_en,
  input  logic [rdd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rdd_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
  localparam int NQ = 1 << rdd_pkg::QNUM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_DIV1, S_WAIT1, S_MUL2, S_CHK, S_WAIT2, S_DONE
  } state_t;

  state_t state;

  logic [rdd_pkg::THR_W-1:0]  min_thresh;
  logic [rdd_pkg::THR_W-1:0]  max_thresh;
  logic [rdd_pkg::PROB_W-1:0] max_prob;
  logic                       marking_mode;

  logic [AW-1:0] qmap [NQ];

  logic [rdd_pkg::QNUM_W-1:0]  qnum;
  logic [rdd_pkg::AVG_W-1:0]   avg;
  logic [rdd_pkg::CUR_W-1:0]   cur;
  logic [rdd_pkg::RND_W-1:0]   rnd;
  logic [AW-1:0]               qi;
  logic [rdd_pkg::COUNT_W-1:0] count;
  logic [rdd_pkg::COUNT_W-1:0] count_next;
  logic [rdd_pkg::QUO_W-1:0]   pb;
  logic signed [38:0]          prod;
  logic [rdd_pkg::ACT_W-1:0]   act;
  logic [NUM_QUEUES-1:0]       qvalid;

  logic                        out_valid;
  logic [rdd_pkg::QNUM_W-1:0]  out_qnum;
  logic [rdd_pkg::ACT_W-1:0]   out_act;

  logic [rdd_pkg::COUNT_W-1:0] ram_rdata;
  logic [rdd_pkg::COUNT_W-1:0] count_rd;
  logic [rdd_pkg::AVG_W-1:0]   lo;
  logic [rdd_pkg::AVG_W-1:0]   hi;
  logic [rdd_pkg::AVG_W-1:0]   avg_off;
  logic [rdd_pkg::PROB_W-1:0]  p_clamp;
  logic                        in_band;
  logic                        above;
  logic                        cur_hit;
  logic signed [20:0]          mul_a;
  logic signed [17:0]          mul_b;
  logic signed [38:0]          mul_p;
  logic signed [39:0]          den;
  logic                        pa_full;
  logic [rdd_pkg::COUNT_W-1:0] count_inc;
  logic [rdd_pkg::ACT_W-1:0]   cong_act;
  logic                        accept;
  logic                        out_free;

  rdd_pkg::div_req_t  dreq;
  rdd_pkg::div_stat_t dstat;

  for (genvar g = 0; g < NQ; g++) begin : g_qmap
    assign qmap[g] = AW'(g % NUM_QUEUES);
  end

  assign accept   = arrival.valid && arrival.ready;
  assign out_free = !out_valid || decision.ready;
  assign cong_act = marking_mode ? rdd_pkg::ACT_MARK : rdd_pkg::ACT_DROP;

  assign count_rd = qvalid[qi] ? ram_rdata : rdd_pkg::COUNT_IDLE;
  assign lo       = {min_thresh, 8'd0};
  assign hi       = {max_thresh, 8'd0};
  assign avg_off  = avg - lo;
  assign p_clamp  = (max_prob > rdd_pkg::ONE_Q16) ? rdd_pkg::ONE_Q16 : max_prob;
  assign in_band  = (avg >= lo) && (avg < hi);
  assign above    = avg >= hi;
  assign cur_hit  = cur >= max_thresh;
  assign count_inc = (count == rdd_pkg::COUNT_MAX) ? count : count + 1'b1;

  always_comb begin
    if (state == S_MUL2) begin
      mul_a = {{5{count[rdd_pkg::COUNT_W-1]}}, count};
      mul_b = {1'b0, pb};
    end else begin
      mul_a = {1'b0, avg_off};
      mul_b = {1'b0, p_clamp};
    end
  end

  assign mul_p = mul_a * mul_b;

  assign den     = 40'sd65536 - {prod[38], prod};
  assign pa_full = den[39] || (den == 40'sd0) || ({23'd0, pb} >= den);

  always_comb begin
    dreq = '0;
    if (state == S_DIV1) begin
      dreq.start    = 1'b1;
      dreq.rem_init = prod[36:17];
      dreq.low_init = prod[16:0];
      dreq.steps    = rdd_pkg::DIV1_STEPS;
      dreq.divisor  = hi - lo;
    end else if (state == S_CHK && !pa_full) begin
      dreq.start    = 1'b1;
      dreq.rem_init = {3'd0, pb};
      dreq.low_init = '0;
      dreq.steps    = rdd_pkg::DIV2_STEPS;
      dreq.divisor  = den[rdd_pkg::DIV_W-1:0];
    end
  end

  rdd_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .stat (dstat)
  );

  rdd_ram #(
    .WIDTH (rdd_pkg::COUNT_W),
    .DEPTH (NUM_QUEUES)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (state == S_DONE && out_free),
    .wr_addr (qi),
    .wr_data (count_next),
    .rd_en   (accept),
    .rd_addr (qmap[arrival.queue_num]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_thresh   <= 12'd16;
      max_thresh   <= 12'd64;
      max_prob     <= 17'd6554;
      marking_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rdd_pkg::CFG_MIN_THRESH:   min_thresh   <= cfg_data[rdd_pkg::THR_W-1:0];
        rdd_pkg::CFG_MAX_THRESH:   max_thresh   <= cfg_data[rdd_pkg::THR_W-1:0];
        rdd_pkg::CFG_MAX_PROB:     max_prob     <= cfg_data;
        rdd_pkg::CFG_MARKING_MODE: marking_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (decision.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            qnum  <= arrival.queue_num;
            avg   <= arrival.avg_length;
            cur   <= arrival.cur_length;
            rnd   <= arrival.random_value;
            qi    <= qmap[arrival.queue_num];
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          count <= count_rd;
          prod  <= mul_p;
          priority if (in_band) begin
            state <= S_DIV1;
          end else if (above || cur_hit) begin
            act        <= cong_act;
            count_next <= rdd_pkg::COUNT_ZERO;
            state      <= S_DONE;
          end else begin
            act        <= rdd_pkg::ACT_ACCEPT;
            count_next <= rdd_pkg::COUNT_IDLE;
            state      <= S_DONE;
          end
        end
        S_DIV1: begin
          state <= S_WAIT1;
        end
        S_WAIT1: begin
          if (dstat.done) begin
            pb    <= dstat.quotient;
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          prod  <= mul_p;
          state <= S_CHK;
        end
        S_CHK: begin
          if (pa_full) begin
            act        <= cong_act;
            count_next <= rdd_pkg::COUNT_ZERO;
            state      <= S_DONE;
          end else begin
            state <= S_WAIT2;
          end
        end
        S_WAIT2: begin
          if (dstat.done) begin
            if ({1'b0, rnd} < dstat.quotient) begin
              act        <= cong_act;
              count_next <= rdd_pkg::COUNT_ZERO;
            end else begin
              act        <= rdd_pkg::ACT_ACCEPT;
              count_next <= count_inc;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_qnum   <= qnum;
            out_act    <= act;
            qvalid[qi] <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign arrival.ready       = (state == S_IDLE);
  assign decision.valid      = out_valid;
  assign decision.queue_echo = out_qnum;
  assign decision.action     = out_act;

endmodule

// ===== sim/red_drop_decision_tb.sv =====
// red_drop_decision_tb: self-checking testbench for the RED drop/mark decision block.
// Drives arrivals and checks decisions against a per-queue count predictor.
// Depends on rdd_pkg, rdd_if and the red_drop_decision RTL.
module red_drop_decision_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdd_pkg::*;

  localparam int NUM_QUEUES = 16;
  localparam int unsigned AVG_MAX = 2**AVG_W - 1;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int SAT_RUN = 20;

  typedef struct packed {
    logic [QNUM_W-1:0] queue_num;
    logic [AVG_W-1:0]  avg_length;
    logic [CUR_W-1:0]  cur_length;
    logic [RND_W-1:0]  random_value;
  } arrival_item_t;

  typedef struct packed {
    logic [QNUM_W-1:0] queue_echo;
    logic [ACT_W-1:0]  action;
  } decision_item_t;

  typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rdd_arrival_if  arrival ();
  rdd_decision_if decision ();

  red_drop_decision #(
    .NUM_QUEUES(NUM_QUEUES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .arrival  (arrival),
    .decision (decision),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [THR_W-1:0]   thr_min  = 12'd16;
  logic [THR_W-1:0]   thr_max  = 12'd64;
  logic [PROB_W-1:0]  prob_max = 17'd6554;
  logic               mark_en  = 1'b0;
  logic [COUNT_W-1:0] since_drop [NUM_QUEUES];

  arrival_item_t  arrival_q [$];
  decision_item_t decision_q [$];
  arrival_item_t  next_arrival;
  decision_item_t want_dec;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int errors = 0;
  int cycle_count = 0;
  int n_checked = 0;
  int n_accept = 0;
  int n_drop = 0;
  int n_mark = 0;
  int n_configs = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic decision_item_t red_decide(arrival_item_t a);
    decision_item_t     d;
    longint unsigned    lo, hi, prob, pb, pa;
    longint             den;
    logic [COUNT_W-1:0] cnt;
    logic [ACT_W-1:0]   congest;
    int unsigned        qi;
    qi = a.queue_num % NUM_QUEUES;
    cnt = since_drop[qi];
    lo = longint'(thr_min) << 8;
    hi = longint'(thr_max) << 8;
    congest = mark_en ? ACT_MARK : ACT_DROP;
    d.queue_echo = a.queue_num;
    d.action = ACT_ACCEPT;
    if (lo <= a.avg_length && a.avg_length < hi) begin
      prob = (prob_max > ONE_Q16) ? longint'(ONE_Q16) : longint'(prob_max);
      pb = prob * (a.avg_length - lo) / (hi - lo);
      den = longint'(ONE_Q16) - longint'($signed(cnt)) * longint'(pb);
      since_drop[qi] = (cnt == COUNT_MAX) ? COUNT_MAX : cnt + 1'b1;
      if (den <= 0) begin
        pa = ONE_Q16;
      end else begin
        pa = (pb << 16) / $unsigned(den);
        if (pa > ONE_Q16) pa = ONE_Q16;
      end
      if (a.random_value < pa) begin
        since_drop[qi] = COUNT_ZERO;
        d.action = congest;
      end
    end else if (a.avg_length >= hi || a.cur_length >= thr_max) begin
      since_drop[qi] = COUNT_ZERO;
      d.action = congest;
    end else begin
      since_drop[qi] = COUNT_IDLE;
    end
    return d;
  endfunction

  function automatic arrival_item_t mk_arrival(int unsigned q, int unsigned avg,
                                               int unsigned cur, int unsigned rnd);
    arrival_item_t a;
    a.queue_num = QNUM_W'(q);
    a.avg_length = AVG_W'(avg);
    a.cur_length = CUR_W'(cur);
    a.random_value = RND_W'(rnd);
    return a;
  endfunction

  // mostly in-band arrivals on a few hot queues so the counts build up
  function automatic arrival_item_t rand_arrival();
    arrival_item_t a;
    int unsigned   lo, hi, sel;
    lo = int'(thr_min) << 8;
    hi = int'(thr_max) << 8;
    sel = $urandom_range(99);
    a.queue_num = ($urandom_range(9) < 7) ? QNUM_W'($urandom_range(3)) : QNUM_W'($urandom);
    a.random_value = $urandom_range(1) ? RND_W'($urandom) : RND_W'($urandom_range(65535, 32768));
    a.avg_length = AVG_W'($urandom);
    a.cur_length = CUR_W'($urandom);
    if (sel < 65 && lo < hi) begin
      a.avg_length = AVG_W'($urandom_range(hi - 1, lo));
    end else if (sel < 75) begin
      a.avg_length = AVG_W'($urandom_range(AVG_MAX, hi));
    end else if (sel < 90 && lo > 0) begin
      a.avg_length = AVG_W'($urandom_range(lo - 1, 0));
      if ($urandom_range(1) == 1 || thr_max == 0)
        a.cur_length = CUR_W'($urandom_range(4095, thr_max));
      else
        a.cur_length = CUR_W'($urandom_range(thr_max - 1, 0));
    end
    return a;
  endfunction

  // sender: hold the item until accepted, then load the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      arrival.valid <= 1'b0;
    end else begin
      if (arrival.valid && arrival.ready) begin
        decision_q.push_back(red_decide({arrival.queue_num, arrival.avg_length,
                                         arrival.cur_length, arrival.random_value}));
      end
      if (!arrival.valid || arrival.ready) begin
        if (arrival_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_arrival = arrival_q.pop_front();
          arrival.queue_num    <= next_arrival.queue_num;
          arrival.avg_length   <= next_arrival.avg_length;
          arrival.cur_length   <= next_arrival.cur_length;
          arrival.random_value <= next_arrival.random_value;
          arrival.valid        <= 1'b1;
        end else begin
          arrival.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each decision with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      decision.ready <= 1'b0;
    end else begin
      if (decision.valid && decision.ready) begin
        if (decision_q.size() == 0) begin
          $error("unexpected decision: queue_echo %0d action %0d",
                 decision.queue_echo, decision.action);
          errors++;
        end else begin
          want_dec = decision_q.pop_front();
          n_checked++;
          case (want_dec.action)
            ACT_ACCEPT: n_accept++;
            ACT_DROP:   n_drop++;
            default:    n_mark++;
          endcase
          if (decision.queue_echo !== want_dec.queue_echo) begin
            $error("queue_echo mismatch: expected %0d, actual %0d",
                   want_dec.queue_echo, decision.queue_echo);
            errors++;
          end
          if (decision.action !== want_dec.action) begin
            $error("action mismatch: expected %0d, actual %0d",
                   want_dec.action, decision.action);
            errors++;
          end
        end
      end
      decision.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic set_idle(idle_mode_e m);
    src_idle_pct = (m == IDLE_SRC) ? 86 : (m == IDLE_BOTH) ? 27 : 0;
    snk_stall_pct = (m == IDLE_SNK) ? 86 : (m == IDLE_BOTH) ? 27 : 0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (arrival_q.size() != 0 || arrival.valid || decision_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_MIN_THRESH: thr_min  = val[THR_W-1:0];
      CFG_MAX_THRESH: thr_max  = val[THR_W-1:0];
      CFG_MAX_PROB:   prob_max = val[PROB_W-1:0];
      default:        mark_en  = val[0];
    endcase
  endtask

  task automatic cfg_set(int unsigned mn, int unsigned mx, int unsigned pr, int unsigned md);
    cfg_write(CFG_MIN_THRESH, CFG_W'(mn));
    cfg_write(CFG_MAX_THRESH, CFG_W'(mx));
    cfg_write(CFG_MAX_PROB, CFG_W'(pr));
    cfg_write(CFG_MARKING_MODE, CFG_W'(md));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    n_configs++;
  endtask

  task automatic run_random(int n, idle_mode_e m);
    set_idle(m);
    repeat (n) arrival_q.push_back(rand_arrival());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    arrival.valid = 1'b0;
    arrival.queue_num = '0;
    arrival.avg_length = '0;
    arrival.cur_length = '0;
    arrival.random_value = '0;
    decision.ready = 1'b0;
    foreach (since_drop[i]) since_drop[i] = COUNT_IDLE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // defaults: band [4096, 16384) in Q12.8
    set_idle(IDLE_NONE);
    arrival_q.push_back(mk_arrival(0, 0, 0, 0));
    arrival_q.push_back(mk_arrival(15, AVG_MAX, 4095, 65535));
    arrival_q.push_back(mk_arrival(1, 4095, 64, 0));
    arrival_q.push_back(mk_arrival(1, 4095, 63, 65535));
    arrival_q.push_back(mk_arrival(2, 4096, 0, 0));
    arrival_q.push_back(mk_arrival(2, 16383, 0, 0));
    arrival_q.push_back(mk_arrival(2, 16384, 0, 65535));
    arrival_q.push_back(mk_arrival(4, 10240, 4095, 32768));
    repeat (12) arrival_q.push_back(mk_arrival(3, 16383, 0, 65535));
    drain();
    n_configs++;

    run_random(60, IDLE_SRC);
    cfg_set(0, 4095, 65536, 1);
    run_random(60, IDLE_SNK);
    cfg_set(100, 50, 131071, 0);
    run_random(50, IDLE_BOTH);
    cfg_set(4095, 4095, 65537, 1);
    run_random(40, IDLE_NONE);
    cfg_set(0, 0, 0, 0);
    run_random(30, IDLE_SRC);
    cfg_set(10, 20, 1000, 0);
    run_random(60, IDLE_SNK);
    // raise the probability on top of the counts built up above
    cfg_set(10, 20, 60000, 1);
    run_random(60, IDLE_BOTH);
    cfg_set(4000, 4095, 32768, 0);
    run_random(60, IDLE_NONE);

    // build up one queue's count with zero probability, then probe it
    cfg_set(16, 64, 0, 0);
    set_idle(IDLE_NONE);
    repeat (SAT_RUN)
      arrival_q.push_back(mk_arrival(5, $urandom_range(16383, 4096), $urandom, $urandom));
    drain();
    cfg_set(16, 64, 2, 0);
    arrival_q.push_back(mk_arrival(5, 10240, 0, 1));
    drain();
    cfg_set(16, 64, 65536, 1);
    arrival_q.push_back(mk_arrival(5, 10240, 0, 65535));
    drain();

    cfg_set(16, 64, 6554, 0);
    run_random(40, IDLE_SRC);

    repeat (50) @(negedge clk);
    $display("Checked %0d decisions over %0d register settings:", n_checked, n_configs);
    $display("  %0d accepted, %0d dropped, %0d marked", n_accept, n_drop, n_mark);
    $display("Included a built-up drop count and crossed, equal and zero thresholds");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rdd_pkg.sv
src/rdd_if.sv
src/rdd_ram.sv
src/rdd_divider.sv
src/red_drop_decision.sv
sim/red_drop_decision_tb.sv
